// ===== rtl/core/fipc_pkg.sv =====
package fipc_pkg;

	// Default sizing
	localparam int NUM_ITEMS_DEF  = 8;
	localparam int COUNT_BITS_DEF = 8;

	// Fixed field widths
	localparam int ITEM_W = 3;
	localparam int SUP_W  = 8;
	localparam int MIN_W  = 8;

	// Result kind codes
	typedef enum logic [1:0] {
		KIND_ITEM = 2'd0,
		KIND_PAIR = 2'd1,
		KIND_NONE = 2'd2
	} kind_t;

endpackage

// ===== rtl/core/frequent_item_pair_counter_top.sv =====
// Update: a repeated or out-of-range item goes straight to the end-of-transaction step; a
// new item walks every usable item, reading and incrementing the pair count with each item
// already present in the transaction, then increments its own item count.
// Report on end of data: each usable item is compared, then each candidate pair of frequent
// items is read from RAM and compared, then a closing step; a stalled output holds the walk.
// One shared saturating incrementer updates every count; one comparator checks every support.
// Reset (arst_n low) clears counts, presence bits, sequencer and output; min_support = 1.
module frequent_item_pair_counter_top
	import fipc_pkg::*;
#(
	parameter int NUM_ITEMS  = NUM_ITEMS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// item input
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ITEM_W-1:0] item_code,
	input  logic              end_of_transaction,
	input  logic              end_of_data,
	// configuration
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MIN_W-1:0]  min_support,
	// result output
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        result_kind,
	output logic [ITEM_W-1:0] first_item,
	output logic [ITEM_W-1:0] second_item,
	output logic [SUP_W-1:0]  support_count,
	output logic              last_result
);

	localparam int U      = (NUM_ITEMS < 8) ? NUM_ITEMS : 8;
	localparam int IDX_W  = $clog2(U);
	localparam int PDEPTH = U * U;
	localparam int AW     = $clog2(PDEPTH);
	localparam int CMP_W  = (COUNT_BITS > SUP_W) ? COUNT_BITS : SUP_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(U - 1);
	localparam logic [IDX_W-1:0] PEN_IDX  = IDX_W'(U - 2);

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_PAIR_RD  = 9'b000000010,
		ST_PAIR_WR  = 9'b000000100,
		ST_ITEM_INC = 9'b000001000,
		ST_TX_END   = 9'b000010000,
		ST_REP_ITEM = 9'b000100000,
		ST_REP_RD   = 9'b001000000,
		ST_REP_CMP  = 9'b010000000,
		ST_REP_DONE = 9'b100000000
	} state_t;

	state_t                 state_q;
	logic [MIN_W-1:0]       min_q;
	logic [IDX_W-1:0]       code_q;
	logic                   eot_q;
	logic                   eod_q;
	logic [IDX_W-1:0]       i_q;
	logic [IDX_W-1:0]       j_q;
	logic [U-1:0]           present_q;
	logic [U-1:0]           freq_q;
	logic [COUNT_BITS-1:0]  item_cnt_q [U];
	logic [PDEPTH-1:0]      pair_vld_q;

	logic                   pend_vld_q;
	kind_t                  pend_kind_q;
	logic [ITEM_W-1:0]      pend_first_q;
	logic [ITEM_W-1:0]      pend_second_q;
	logic [SUP_W-1:0]       pend_sup_q;

	logic                   out_valid_q;
	kind_t                  out_kind_q;
	logic [ITEM_W-1:0]      out_first_q;
	logic [ITEM_W-1:0]      out_second_q;
	logic [SUP_W-1:0]       out_sup_q;
	logic                   out_last_q;

	logic                   in_acc;
	logic                   code_ok;
	logic [IDX_W-1:0]       in_idx;
	logic [IDX_W-1:0]       lo;
	logic [IDX_W-1:0]       hi;
	logic [AW-1:0]          pair_addr;
	logic                   ram_we;
	logic                   ram_re;
	logic [COUNT_BITS-1:0]  ram_rdata;
	logic [COUNT_BITS-1:0]  pair_cur;
	logic [IDX_W-1:0]       item_idx;
	logic [COUNT_BITS-1:0]  item_rd;
	logic [COUNT_BITS-1:0]  inc_in;
	logic [COUNT_BITS-1:0]  inc_out;
	logic [COUNT_BITS-1:0]  cmp_in;
	logic                   cmp_hit;
	logic                   out_free;
	logic                   hit_step;
	logic                   can_emit;
	logic                   load_out;
	kind_t                  new_kind;
	logic [ITEM_W-1:0]      new_first;
	logic [ITEM_W-1:0]      new_second;
	logic [SUP_W-1:0]       new_sup;
	logic                   upd_last;
	logic                   rep_pair_last;

	// Clamp a count to the 8-bit reported support
	function automatic logic [SUP_W-1:0] sup_clamp(input logic [COUNT_BITS-1:0] v);
		logic [CMP_W-1:0] ext;
		ext = CMP_W'(v);
		return (ext > CMP_W'(8'hFF)) ? 8'hFF : ext[SUP_W-1:0];
	endfunction

	// Handshakes
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign code_ok = ({1'b0, item_code} < (ITEM_W + 1)'(U));
	assign in_idx  = item_code[IDX_W-1:0];

	// Select pair coordinates: update pairs code with j, report walks i < j
	always_comb begin
		if (state_q == ST_REP_RD || state_q == ST_REP_CMP) begin
			lo = i_q;
			hi = j_q;
		end else if (j_q < code_q) begin
			lo = j_q;
			hi = code_q;
		end else begin
			lo = code_q;
			hi = j_q;
		end
	end

	assign pair_addr = AW'(lo) * AW'(U) + AW'(hi);
	assign ram_we    = (state_q == ST_PAIR_WR);
	assign ram_re    = ((state_q == ST_PAIR_RD) && present_q[j_q]) ||
	                   ((state_q == ST_REP_RD) && freq_q[i_q] && freq_q[j_q]);
	assign pair_cur  = pair_vld_q[pair_addr] ? ram_rdata : '0;

	fipc_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(PDEPTH)
	) u_pair_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pair_addr),
		.wdata (inc_out),
		.re    (ram_re),
		.raddr (pair_addr),
		.rdata (ram_rdata)
	);

	// Shared incrementer and comparator
	assign item_idx = (state_q == ST_REP_ITEM) ? i_q : code_q;
	assign item_rd  = item_cnt_q[item_idx];
	assign inc_in   = (state_q == ST_PAIR_WR) ? pair_cur : item_rd;
	assign inc_out  = (&inc_in) ? inc_in : inc_in + 1'b1;
	assign cmp_in   = (state_q == ST_REP_CMP) ? pair_cur : item_rd;
	assign cmp_hit  = CMP_W'(cmp_in) >= CMP_W'(min_q);

	// Candidate result from the report walk
	assign new_kind   = (state_q == ST_REP_ITEM) ? KIND_ITEM : KIND_PAIR;
	assign new_first  = ITEM_W'(i_q);
	assign new_second = (state_q == ST_REP_ITEM) ? '0 : ITEM_W'(j_q);
	assign new_sup    = sup_clamp(cmp_in);

	assign hit_step = ((state_q == ST_REP_ITEM) || (state_q == ST_REP_CMP)) && cmp_hit;
	assign can_emit = !pend_vld_q || out_free;
	assign load_out = (hit_step && pend_vld_q && out_free) ||
	                  ((state_q == ST_REP_DONE) && out_free);

	assign upd_last      = (j_q == LAST_IDX);
	assign rep_pair_last = (j_q == LAST_IDX) && (i_q == PEN_IDX);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			min_q      <= MIN_W'(1);
			code_q     <= '0;
			eot_q      <= 1'b0;
			eod_q      <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			present_q  <= '0;
			freq_q     <= '0;
			pair_vld_q <= '0;
			pend_vld_q <= 1'b0;
			for (int k = 0; k < U; k++) begin
				item_cnt_q[k] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				min_q <= min_support;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						code_q <= in_idx;
						eot_q  <= end_of_transaction;
						eod_q  <= end_of_data;
						j_q    <= '0;
						if (code_ok && !present_q[in_idx]) begin
							state_q <= ST_PAIR_RD;
						end else begin
							state_q <= ST_TX_END;
						end
					end
				end
				ST_PAIR_RD: begin
					// skip items not in this transaction
					if (present_q[j_q]) begin
						state_q <= ST_PAIR_WR;
					end else if (upd_last) begin
						state_q <= ST_ITEM_INC;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_PAIR_WR: begin
					pair_vld_q[pair_addr] <= 1'b1;
					if (upd_last) begin
						state_q <= ST_ITEM_INC;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_PAIR_RD;
					end
				end
				ST_ITEM_INC: begin
					item_cnt_q[code_q] <= inc_out;
					present_q[code_q]  <= 1'b1;
					state_q            <= ST_TX_END;
				end
				ST_TX_END: begin
					if (eot_q || eod_q) begin
						present_q <= '0;
					end
					if (eod_q) begin
						i_q     <= '0;
						state_q <= ST_REP_ITEM;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_REP_ITEM: begin
					// hold while a hit cannot move the pending result out
					if (!cmp_hit || can_emit) begin
						if (cmp_hit) begin
							freq_q[i_q] <= 1'b1;
						end
						if (i_q == LAST_IDX) begin
							i_q     <= '0;
							j_q     <= IDX_W'(1);
							state_q <= ST_REP_RD;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				ST_REP_RD: begin
					if (freq_q[i_q] && freq_q[j_q]) begin
						state_q <= ST_REP_CMP;
					end else if (rep_pair_last) begin
						state_q <= ST_REP_DONE;
					end else if (j_q == LAST_IDX) begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + IDX_W'(2);
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_REP_CMP: begin
					if (!cmp_hit || can_emit) begin
						if (rep_pair_last) begin
							state_q <= ST_REP_DONE;
						end else begin
							state_q <= ST_REP_RD;
							if (j_q == LAST_IDX) begin
								i_q <= i_q + 1'b1;
								j_q <= i_q + IDX_W'(2);
							end else begin
								j_q <= j_q + 1'b1;
							end
						end
					end
				end
				ST_REP_DONE: begin
					// flush the final result and clear all counts
					if (out_free) begin
						freq_q     <= '0;
						pair_vld_q <= '0;
						for (int k = 0; k < U; k++) begin
							item_cnt_q[k] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Advance the pending result
			if (hit_step && can_emit) begin
				pend_vld_q <= 1'b1;
			end else if ((state_q == ST_REP_DONE) && out_free) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	// Pending result payload
	always_ff @(posedge clk) begin
		if (hit_step && can_emit) begin
			pend_kind_q   <= new_kind;
			pend_first_q  <= new_first;
			pend_second_q <= new_second;
			pend_sup_q    <= new_sup;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload: pending result, or none when nothing qualified
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_last_q <= (state_q == ST_REP_DONE);
			if (pend_vld_q) begin
				out_kind_q   <= pend_kind_q;
				out_first_q  <= pend_first_q;
				out_second_q <= pend_second_q;
				out_sup_q    <= pend_sup_q;
			end else begin
				out_kind_q   <= KIND_NONE;
				out_first_q  <= '0;
				out_second_q <= '0;
				out_sup_q    <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = out_kind_q;
	assign first_item    = out_first_q;
	assign second_item   = out_second_q;
	assign support_count = out_sup_q;
	assign last_result   = out_last_q;

endmodule

// ===== rtl/core/fipc_ram.sv =====
module fipc_ram
	import fipc_pkg::*;
#(
	parameter int WIDTH = COUNT_BITS_DEF,
	parameter int DEPTH = NUM_ITEMS_DEF * NUM_ITEMS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/fipc_checker.sv =====
module fipc_checker
	import fipc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [ITEM_W-1:0] item_code,
	input logic              end_of_transaction,
	input logic              end_of_data,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic [MIN_W-1:0]  min_support,
	input logic              out_valid,
	input logic              out_stall,
	input logic [1:0]        result_kind,
	input logic [ITEM_W-1:0] first_item,
	input logic [ITEM_W-1:0] second_item,
	input logic [SUP_W-1:0]  support_count,
	input logic              last_result
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind) &&
		$stable(first_item) && $stable(second_item) && $stable(support_count) &&
		$stable(last_result))
	else $error("stalled result changed");

	// An accepted item keeps the input stalled in the cycle after it
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
	else $error("input accepted back to back");

	// A none result stands alone and is final
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_NONE) |->
		last_result && (first_item == '0) && (second_item == '0) && (support_count == '0))
	else $error("malformed none result");

	// Single items carry no second code
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_ITEM) |-> (second_item == '0))
	else $error("single item with second code");

	// Pairs come in ascending code order
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_PAIR) |-> (first_item < second_item))
	else $error("pair codes out of order");

endmodule

bind frequent_item_pair_counter_top fipc_checker u_fipc_checker (.*);

// ===== sim/frequent_item_pair_counter_top_tb.sv =====
`timescale 1ns / 100ps

module frequent_item_pair_counter_top_tb;
	import fipc_pkg::*;

	localparam int NUM_ITEMS      = NUM_ITEMS_DEF;
	localparam int COUNT_BITS     = COUNT_BITS_DEF;
	localparam int USABLE         = (NUM_ITEMS < 8) ? NUM_ITEMS : 8;
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 100;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ITEM_W-1:0] first;
		logic [ITEM_W-1:0] second;
		logic [SUP_W-1:0]  support;
		logic              last;
	} report_t;

	// Support counting model and queue of expected report entries
	class support_scoreboard;
		logic [MIN_W-1:0] min_sup;
		logic [7:0]       present;
		int unsigned      item_sup [8];
		int unsigned      pair_sup [8][8];
		report_t          expected_reports [$];
		int               errors;
		int               items_seen;
		int               sets_seen;
		int               entries_checked;

		function new();
			min_sup = 8'd1;
			present = '0;
			errors = 0;
			items_seen = 0;
			sets_seen = 0;
			entries_checked = 0;
			clear_counts();
		endfunction

		function void clear_counts();
			for (int i = 0; i < 8; i++) begin
				item_sup[i] = 0;
				for (int j = 0; j < 8; j++)
					pair_sup[i][j] = 0;
			end
		endfunction

		function int unsigned bump(int unsigned v);
			int unsigned top;
			top = (32'd1 << COUNT_BITS) - 1;
			return (v >= top) ? top : v + 1;
		endfunction

		function logic [SUP_W-1:0] shown(int unsigned v);
			return (v > 255) ? 8'd255 : v[SUP_W-1:0];
		endfunction

		function void set_min(logic [MIN_W-1:0] value);
			min_sup = value;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		// Count one purchased item; build the report when the data ends
		function void count_item(logic [ITEM_W-1:0] code, logic eot, logic eod);
			int lo;
			int hi;
			report_t r;
			report_t batch [$];
			items_seen++;
			if (code < USABLE && !present[code]) begin
				for (int j = 0; j < USABLE; j++) begin
					if (present[j]) begin
						lo = (j < code) ? j : code;
						hi = (j < code) ? code : j;
						pair_sup[lo][hi] = bump(pair_sup[lo][hi]);
					end
				end
				item_sup[code] = bump(item_sup[code]);
				present[code] = 1'b1;
			end
			if (eot || eod)
				present = '0;
			if (!eod)
				return;
			sets_seen++;
			for (int i = 0; i < USABLE; i++) begin
				if (item_sup[i] >= min_sup) begin
					r = '{KIND_ITEM, ITEM_W'(i), '0, shown(item_sup[i]), 1'b0};
					batch.push_back(r);
				end
			end
			for (int i = 0; i < USABLE; i++) begin
				if (item_sup[i] >= min_sup) begin
					for (int j = i + 1; j < USABLE; j++) begin
						if (item_sup[j] >= min_sup && pair_sup[i][j] >= min_sup) begin
							r = '{KIND_PAIR, ITEM_W'(i), ITEM_W'(j),
								shown(pair_sup[i][j]), 1'b0};
							batch.push_back(r);
						end
					end
				end
			end
			if (batch.size() == 0) begin
				r = '{KIND_NONE, '0, '0, '0, 1'b0};
				batch.push_back(r);
			end
			for (int k = 0; k < batch.size(); k++) begin
				r = batch[k];
				r.last = (k == batch.size() - 1);
				expected_reports.push_back(r);
			end
			clear_counts();
		endfunction

		// Compare one report entry with the oldest expectation
		function void check_entry(logic [1:0] kind, logic [ITEM_W-1:0] first,
			logic [ITEM_W-1:0] second, logic [SUP_W-1:0] support, logic last);
			report_t want;
			if (expected_reports.size() == 0) begin
				$error("report entry with nothing expected: kind %0d first %0d second %0d",
					kind, first, second);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			entries_checked++;
			if (kind !== want.kind) begin
				$error("result_kind: expected %0d, actual %0d", want.kind, kind);
				errors++;
			end
			if (first !== want.first) begin
				$error("first_item: expected %0d, actual %0d", want.first, first);
				errors++;
			end
			if (second !== want.second) begin
				$error("second_item: expected %0d, actual %0d", want.second, second);
				errors++;
			end
			if (support !== want.support) begin
				$error("support_count: expected %0d, actual %0d", want.support, support);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_result: expected %0d, actual %0d", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [ITEM_W-1:0] item_code;
	logic              end_of_transaction;
	logic              end_of_data;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [MIN_W-1:0]  min_support;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        result_kind;
	logic [ITEM_W-1:0] first_item;
	logic [ITEM_W-1:0] second_item;
	logic [SUP_W-1:0]  support_count;
	logic              last_result;

	support_scoreboard sb;
	int                send_idle_pct;
	int                recv_stall_pct;
	int                holds_asked;
	int                idle_cycles;
	int                random_items;
	bit                progress;

	frequent_item_pair_counter_top #(
		.NUM_ITEMS (NUM_ITEMS),
		.COUNT_BITS(COUNT_BITS)
	) u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.item_code         (item_code),
		.end_of_transaction(end_of_transaction),
		.end_of_data       (end_of_data),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.min_support       (min_support),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.result_kind       (result_kind),
		.first_item        (first_item),
		.second_item       (second_item),
		.support_count     (support_count),
		.last_result       (last_result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Sample handshakes at the edge and run the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			progress = 1'b0;
			if (cfg_valid && cfg_ready) begin
				sb.set_min(min_support);
				progress = 1'b1;
			end
			if (in_valid && !in_stall) begin
				sb.count_item(item_code, end_of_transaction, end_of_data);
				progress = 1'b1;
			end
			if (out_valid && !out_stall) begin
				sb.check_entry(result_kind, first_item, second_item, support_count,
					last_result);
				progress = 1'b1;
			end
			idle_cycles = progress ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", idle_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Stall the output at random; hold it off for a long stretch on request
	initial begin
		int hold_left;
		int holds_seen;
		hold_left = 0;
		holds_seen = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_seen != holds_asked) begin
				holds_seen = holds_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// Offer one item, idling first at random, and wait until it is taken
	task automatic offer_item(input logic [ITEM_W-1:0] code, input logic eot,
		input logic eod);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		item_code <= code;
		end_of_transaction <= eot;
		end_of_data <= eod;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid, wait for every report entry, then let the block settle
	task automatic wait_reports_done();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_support(input logic [MIN_W-1:0] value);
		cfg_valid <= 1'b1;
		min_support <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Send one data set: transactions drawn mostly from a few popular items
	task automatic send_random_set(input int n_trans, input int max_len);
		logic [ITEM_W-1:0] hot [3];
		logic [ITEM_W-1:0] code;
		logic              eot;
		logic              eod;
		int                len;
		for (int h = 0; h < 3; h++)
			hot[h] = ITEM_W'($urandom_range(0, 7));
		for (int t = 0; t < n_trans; t++) begin
			len = $urandom_range(1, max_len);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 99) < 70)
					code = hot[$urandom_range(0, 2)];
				else
					code = ITEM_W'($urandom_range(0, 7));
				eod = (t == n_trans - 1) && (k == len - 1);
				if (k == len - 1)
					eot = ($urandom_range(0, 9) != 0);
				else
					eot = ($urandom_range(0, 19) == 0);
				offer_item(code, eot, eod);
				random_items++;
			end
		end
	endtask

	task automatic pick_min_support();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			write_min_support(8'd0);
		else if (roll == 1)
			write_min_support(8'd255);
		else
			write_min_support(MIN_W'($urandom_range(1, 4)));
	endtask

	initial begin
		logic [ITEM_W-1:0] a;
		int                mode_items;
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holds_asked = 0;
		idle_cycles = 0;
		random_items = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		item_code <= '0;
		end_of_transaction <= 1'b0;
		end_of_data <= 1'b0;
		cfg_valid <= 1'b0;
		min_support <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset minimum: repeated item, duplicate in mid transaction, end flags together
		offer_item(3'd3, 1'b0, 1'b0);
		offer_item(3'd3, 1'b0, 1'b0);
		offer_item(3'd5, 1'b1, 1'b0);
		offer_item(3'd7, 1'b0, 1'b0);
		offer_item(3'd0, 1'b0, 1'b0);
		offer_item(3'd7, 1'b1, 1'b0);
		offer_item(3'd2, 1'b1, 1'b1);
		wait_reports_done();

		// Full transaction of every code, then end of data without end of transaction
		write_min_support(8'd2);
		for (int c = 0; c < 8; c++)
			offer_item(ITEM_W'(c), c == 7, 1'b0);
		offer_item(3'd1, 1'b0, 1'b0);
		offer_item(3'd6, 1'b0, 1'b1);
		wait_reports_done();

		// Nothing qualifies
		write_min_support(8'd255);
		offer_item(3'd4, 1'b0, 1'b1);
		wait_reports_done();

		// Zero minimum: every item and pair, zero support included
		write_min_support(8'd0);
		offer_item(3'd6, 1'b1, 1'b1);
		wait_reports_done();

		// Saturate one item count past the count range
		write_min_support(8'd255);
		a = ITEM_W'($urandom_range(0, 7));
		for (int t = 0; t < 257; t++)
			offer_item(a, 1'b1, t == 256);
		wait_reports_done();

		// Hold the output off while data sets keep coming
		write_min_support(8'd1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holds_asked++;
		for (int s = 0; s < 3; s++)
			send_random_set($urandom_range(3, 6), 4);
		wait_reports_done();

		// Random data sets under each idling pattern
		random_items = 0;
		for (int mode = 0; mode < 4; mode++) begin
			send_idle_pct = (mode == 1) ? 54 : (mode == 3) ? 27 : 0;
			recv_stall_pct = (mode == 2) ? 54 : (mode == 3) ? 27 : 0;
			mode_items = random_items;
			while (random_items - mode_items < RANDOM_ITEMS / 4) begin
				pick_min_support();
				send_random_set($urandom_range(2, 10), 5);
				wait_reports_done();
			end
		end

		$display("Checked %0d report entries from %0d data sets over %0d items.",
			sb.entries_checked, sb.sets_seen, sb.items_seen);
		$display("Minimums 0, 1, 2, 255 and random low values; count saturation; long output hold.");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/fipc_pkg.sv
rtl/core/fipc_ram.sv
rtl/core/frequent_item_pair_counter_top.sv
rtl/core/fipc_checker.sv
sim/frequent_item_pair_counter_top_tb.sv
